FILE: sv/psch_pkg.sv
package psch_pkg;

    localparam int MAX_TASKS    = 8;
    localparam int TIME_WIDTH   = 32;
    localparam int HANDLE_WIDTH = 16;
    localparam int SLOT_W       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    localparam logic [2:0] FUNC_ADD_PER = 3'd0;
    localparam logic [2:0] FUNC_ADD_AT  = 3'd1;
    localparam logic [2:0] FUNC_DEL     = 3'd2;
    localparam logic [2:0] FUNC_CHG     = 3'd3;
    localparam logic [2:0] FUNC_TICK    = 3'd4;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_DUE  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    typedef struct packed {
        logic [2:0]  func;
        logic [2:0]  slot_id;
        logic [15:0] task_handle;
        logic [31:0] period;
        logic [31:0] start_time;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic        status;
        logic [2:0]  slot_id_res;
        logic [15:0] task_handle_res;
        logic        last;
    } t_out;

    // command broadcast to every cell
    typedef struct packed {
        logic                    add;
        logic                    del;
        logic                    chg;
        logic                    adv;
        logic [2:0]              slot;
        logic [HANDLE_WIDTH-1:0] handle;
        logic [TIME_WIDTH-1:0]   period;
        logic [TIME_WIDTH-1:0]   due;
    } t_cmd;

    // status reported by each cell
    typedef struct packed {
        logic                    valid;
        logic                    match;
        logic                    take;
        logic                    hit;
        logic [HANDLE_WIDTH-1:0] handle;
    } t_cell_st;

endpackage

FILE: sv/psch_if.sv
interface psch_in_if import psch_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface psch_out_if import psch_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/psch_cell.sv
module psch_cell import psch_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [SLOT_W-1:0]     i_idx,
    input  t_cmd                  i_cmd,
    input  logic [TIME_WIDTH-1:0] i_time,
    input  logic                  i_free_in,
    output logic                  o_free_out,
    input  logic                  i_tok_in,
    output logic                  o_tok,
    output t_cell_st              o_st
);

    logic                    r_valid;
    logic                    r_tok;
    logic [HANDLE_WIDTH-1:0] r_handle;
    logic [TIME_WIDTH-1:0]   r_period;
    logic [TIME_WIDTH-1:0]   r_due;

    logic match;
    logic take;
    logic due_now;
    logic rearm;

    assign match   = r_valid && (32'(i_cmd.slot) == 32'(i_idx));
    assign take    = i_cmd.add && !r_valid && !i_free_in;
    assign due_now = r_valid && (i_time >= r_due);
    assign rearm   = i_cmd.adv && r_tok && due_now;

    assign o_free_out = i_free_in || !r_valid;
    assign o_tok      = r_tok;

    assign o_st.valid  = r_valid;
    assign o_st.match  = match;
    assign o_st.take   = take;
    assign o_st.hit    = r_tok && due_now;
    assign o_st.handle = r_handle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
            end else if (i_cmd.del && match) begin
                r_valid <= 1'b0;
            end
            if (i_cmd.adv) begin
                r_tok <= i_tok_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_handle <= i_cmd.handle;
            r_period <= i_cmd.period;
            r_due    <= i_cmd.due;
        end else if (i_cmd.chg && match) begin
            r_period <= i_cmd.period;
        end else if (rearm) begin
            r_due <= i_time + r_period;
        end
    end

endmodule

FILE: sv/periodic_task_due_scheduler_top.sv
// channel  | dir | payload                                              | handshake
// i_req    | in  | func, slot_id, task_handle, period, start_time       | valid/ready
// o_res    | out | kind, status, slot_id_res, task_handle_res, last     | valid/ready
//
// add, delete, change and unknown requests each give one result
// a tick starts a scan: a scan token walks the row of slot cells, one cell per cycle
// while the output register can load, then the scan-finished result is issued
// a stalled output register holds the scan token and the request channel
// reset clears the slot valid bits, the token and the tick counter

module periodic_task_due_scheduler_top import psch_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psch_in_if.sink    i_req,
    psch_out_if.source o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [TIME_WIDTH-1:0] r_time;
    logic                  r_ov;
    logic                  n_ov;
    t_out                  r_out;
    t_out                  n_out;

    t_cmd                  cmd;
    t_cell_st              st       [MAX_TASKS];
    logic [MAX_TASKS:0]    free_chain;
    logic [MAX_TASKS-1:0]  tok_vec;
    logic [MAX_TASKS-1:0]  tok_in;
    logic [MAX_TASKS-1:0]  valid_vec;

    logic                    acc;
    logic                    can_load;
    logic                    start;
    logic                    full;
    logic                    match_any;
    logic                    hit_any;
    logic [SLOT_W-1:0]       hit_idx;
    logic [SLOT_W-1:0]       take_idx;
    logic [HANDLE_WIDTH-1:0] hit_handle;

    assign can_load    = !r_ov || o_res.ready;
    assign i_req.ready = (r_state == ST_IDLE) && can_load;
    assign acc         = i_req.valid && i_req.ready;
    assign start       = acc && (i_req.data.func == FUNC_TICK);
    assign full        = !free_chain[MAX_TASKS];

    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    always_comb begin
        cmd.add    = acc && (i_req.data.func == FUNC_ADD_PER || i_req.data.func == FUNC_ADD_AT);
        cmd.del    = acc && (i_req.data.func == FUNC_DEL);
        cmd.chg    = acc && (i_req.data.func == FUNC_CHG);
        cmd.adv    = start || ((r_state == ST_SCAN) && can_load);
        cmd.slot   = i_req.data.slot_id;
        cmd.handle = HANDLE_WIDTH'(i_req.data.task_handle);
        cmd.period = (i_req.data.func == FUNC_ADD_AT) ? '0 : TIME_WIDTH'(i_req.data.period);
        cmd.due    = (i_req.data.func == FUNC_ADD_AT) ? TIME_WIDTH'(i_req.data.start_time) : '0;
    end

    assign free_chain[0] = 1'b0;

    always_comb begin
        tok_in[0] = start;
        for (int i = 1; i < MAX_TASKS; i++) begin
            tok_in[i] = tok_vec[i-1];
        end
    end

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        psch_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_idx      (SLOT_W'(g)),
            .i_cmd      (cmd),
            .i_time     (r_time),
            .i_free_in  (free_chain[g]),
            .o_free_out (free_chain[g+1]),
            .i_tok_in   (tok_in[g]),
            .o_tok      (tok_vec[g]),
            .o_st       (st[g])
        );
        assign valid_vec[g] = st[g].valid;
    end

    always_comb begin
        match_any  = 1'b0;
        hit_any    = 1'b0;
        hit_idx    = '0;
        take_idx   = '0;
        hit_handle = '0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            match_any = match_any | st[i].match;
            if (st[i].hit) begin
                hit_any    = 1'b1;
                hit_idx    = hit_idx | SLOT_W'(i);
                hit_handle = hit_handle | st[i].handle;
            end
            if (st[i].take) begin
                take_idx = take_idx | SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_ov    = r_ov && !o_res.ready;
        n_out   = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_out.kind            = KIND_ACK;
                    n_out.status          = STAT_ERR;
                    n_out.slot_id_res     = '0;
                    n_out.task_handle_res = '0;
                    n_out.last            = 1'b1;
                    n_ov                  = 1'b1;
                    priority if (i_req.data.func == FUNC_TICK) begin
                        n_ov    = r_ov && !o_res.ready;
                        n_out   = r_out;
                        n_state = ST_SCAN;
                    end else if (cmd.add) begin
                        if (!full) begin
                            n_out.status          = STAT_OK;
                            n_out.slot_id_res     = 3'(take_idx);
                            n_out.task_handle_res = 16'(cmd.handle);
                        end
                    end else if (cmd.del || cmd.chg) begin
                        n_out.status      = match_any ? STAT_OK : STAT_ERR;
                        n_out.slot_id_res = i_req.data.slot_id;
                    end else begin
                        n_out.status = STAT_ERR;
                    end
                end
            end
            ST_SCAN: begin
                if (can_load) begin
                    if (hit_any) begin
                        n_out.kind            = KIND_DUE;
                        n_out.status          = STAT_OK;
                        n_out.slot_id_res     = 3'(hit_idx);
                        n_out.task_handle_res = 16'(hit_handle);
                        n_out.last            = 1'b0;
                        n_ov                  = 1'b1;
                    end
                    if (tok_vec[MAX_TASKS-1]) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (can_load) begin
                    n_out.kind            = KIND_DONE;
                    n_out.status          = STAT_OK;
                    n_out.slot_id_res     = '0;
                    n_out.task_handle_res = '0;
                    n_out.last            = 1'b1;
                    n_ov                  = 1'b1;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_time  <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (start) begin
                r_time <= r_time + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_tok_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vec))
        else $error("more than one scan token");

    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> $onehot(tok_vec))
        else $error("scan state without a token");

    a_tick_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (r_state == ST_SCAN) && tok_vec[0])
        else $error("tick did not start the scan at slot 0");

    a_full_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.add && full) |=> $stable(valid_vec))
        else $error("add on full table changed slots");

    a_time_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |=> $stable(r_time))
        else $error("time moved without a tick");
`endif

endmodule
